### rtl/tscal_pkg.sv
// ----------------------------------------------------------------------------
// tscal_pkg
// Shared types, register map and constants of the touch calibration core.
// ----------------------------------------------------------------------------
package tscal_pkg;

    // converter frame and raw sample
    localparam int FRAME_W     = 16;
    localparam int FRAME_SHIFT = 3;
    localparam int RAW_W       = FRAME_W - FRAME_SHIFT;
    localparam int SAMPLE_BITS_DEF = 12;

    // acceptance window on the raw sample
    localparam logic [RAW_W-1:0] WIN_LOW  = RAW_W'(100);
    localparam logic [RAW_W-1:0] WIN_HIGH = RAW_W'(4000);

    // field widths
    localparam int ORIENT_W = 2;
    localparam int OFF_W    = 12;
    localparam int GAIN_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 12;
    localparam int POS_W    = 12;

    // apb
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ORIENT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_GAIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_GAIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

    // reset values
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(65536);
    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(240);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(320);

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_PORTRAIT      = 2'd0,
        ORIENT_LANDSCAPE     = 2'd1,
        ORIENT_PORTRAIT_180  = 2'd2,
        ORIENT_LANDSCAPE_270 = 2'd3
    } t_orient;

    typedef struct packed {
        logic [ORIENT_W-1:0] orientation;
        logic [OFF_W-1:0]    x_offset;
        logic [OFF_W-1:0]    y_offset;
        logic [GAIN_W-1:0]   x_gain;
        logic [GAIN_W-1:0]   y_gain;
        logic [SIZE_W-1:0]   screen_width;
        logic [SIZE_W-1:0]   screen_height;
    } t_cfg;

endpackage

### rtl/touch_sample_calibrate_orient_core.sv
// ----------------------------------------------------------------------------
// touch_sample_calibrate_orient_core
// Touch sample calibration: level-change detection, window check, offset and
// gain per axis, orientation and screen clamp, with an APB register port.
// ----------------------------------------------------------------------------
// pipeline: a result passes the input register, the scale register and the
//   result register before it is on m_axis
// throughput: one word per cycle; each stage moves up when it is empty or the
//   one after it moves, so a held result stalls input once all stages are full
// reset: synchronous, active low; clears the pipeline valids, the last touch
//   level (not pressed) and all APB registers to their reset values
// ----------------------------------------------------------------------------
module touch_sample_calibrate_orient_core
    import tscal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // apb
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // x_frame[15:0], y_frame[31:16]
    input  logic              s_axis_tuser,  // touch_level[0]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // pos_x[11:0], pos_y[23:12],
                                             // orient_used[25:24], zero[31:26]
    output logic              m_axis_tuser   // is_pressed[0]
);

    t_cfg cfg;

    tscal_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    assign pready = 1'b1;

    // handshake between stages
    logic en_o;
    logic en2;
    logic en1;
    logic acc;

    logic r_last_level;

    logic             r1_v;
    logic             r1_level;
    logic [RAW_W-1:0] r1_rx;
    logic [RAW_W-1:0] r1_ry;

    logic               r2_v;
    logic               r2_level;
    logic [COORD_W-1:0] r2_cx;
    logic [COORD_W-1:0] r2_cy;

    logic                r_out_v;
    logic                r_out_level;
    logic [POS_W-1:0]    r_pos_x;
    logic [POS_W-1:0]    r_pos_y;
    logic [ORIENT_W-1:0] r_orient;

    logic               n_r1_v;
    logic               n_r2_v;
    logic               win_x;
    logic               win_y;
    logic [COORD_W-1:0] n_cx;
    logic [COORD_W-1:0] n_cy;
    logic [POS_W-1:0]   n_pos_x;
    logic [POS_W-1:0]   n_pos_y;

    assign en_o = !r_out_v || m_axis_tready;
    assign en2  = !r2_v || en_o;
    assign en1  = !r1_v || en2;
    assign acc  = s_axis_tvalid && en1;

    assign s_axis_tready = en1;

    // only a change of touch level goes on
    assign n_r1_v = acc && (s_axis_tuser != r_last_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
        end else if (acc) begin
            r_last_level <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= n_r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_level <= s_axis_tuser;
            r1_rx    <= s_axis_tdata[FRAME_W-1:FRAME_SHIFT];
            r1_ry    <= s_axis_tdata[2*FRAME_W-1:FRAME_W+FRAME_SHIFT];
        end
    end

    tscal_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_x (
        .i_raw    (r1_rx),
        .i_offset (cfg.x_offset),
        .i_gain   (cfg.x_gain),
        .o_in_win (win_x),
        .o_coord  (n_cx)
    );

    tscal_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale_y (
        .i_raw    (r1_ry),
        .i_offset (cfg.y_offset),
        .i_gain   (cfg.y_gain),
        .o_in_win (win_y),
        .o_coord  (n_cy)
    );

    // a press outside the window is dropped here
    assign n_r2_v = r1_v && (!r1_level || (win_x && win_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= n_r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_level <= r1_level;
            r2_cx    <= n_cx;
            r2_cy    <= n_cy;
        end
    end

    tscal_orient u_orient (
        .i_level  (r2_level),
        .i_cx     (r2_cx),
        .i_cy     (r2_cy),
        .i_orient (cfg.orientation),
        .i_width  (cfg.screen_width),
        .i_height (cfg.screen_height),
        .o_pos_x  (n_pos_x),
        .o_pos_y  (n_pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_o) begin
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out_level <= r2_level;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_orient    <= cfg.orientation;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_level;
    assign m_axis_tdata  = {6'd0, r_orient, r_pos_y, r_pos_x};

endmodule

### rtl/tscal_regs.sv
// ----------------------------------------------------------------------------
// tscal_regs
// APB register file: orientation, offsets, gains and screen size.
// ----------------------------------------------------------------------------
module tscal_regs
    import tscal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign wr_en = i_psel && i_penable && i_pwrite;
    assign idx   = i_paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation   <= '0;
            r_cfg.x_offset      <= '0;
            r_cfg.y_offset      <= '0;
            r_cfg.x_gain        <= GAIN_RST;
            r_cfg.y_gain        <= GAIN_RST;
            r_cfg.screen_width  <= WIDTH_RST;
            r_cfg.screen_height <= HEIGHT_RST;
        end else if (wr_en) begin
            case (idx)
                REG_ORIENT:   r_cfg.orientation   <= i_pwdata[ORIENT_W-1:0];
                REG_X_OFFSET: r_cfg.x_offset      <= i_pwdata[OFF_W-1:0];
                REG_Y_OFFSET: r_cfg.y_offset      <= i_pwdata[OFF_W-1:0];
                REG_X_GAIN:   r_cfg.x_gain        <= i_pwdata[GAIN_W-1:0];
                REG_Y_GAIN:   r_cfg.y_gain        <= i_pwdata[GAIN_W-1:0];
                REG_WIDTH:    r_cfg.screen_width  <= i_pwdata[SIZE_W-1:0];
                REG_HEIGHT:   r_cfg.screen_height <= i_pwdata[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ORIENT:   o_prdata = APB_DW'(r_cfg.orientation);
            REG_X_OFFSET: o_prdata = APB_DW'(r_cfg.x_offset);
            REG_Y_OFFSET: o_prdata = APB_DW'(r_cfg.y_offset);
            REG_X_GAIN:   o_prdata = APB_DW'(r_cfg.x_gain);
            REG_Y_GAIN:   o_prdata = APB_DW'(r_cfg.y_gain);
            REG_WIDTH:    o_prdata = APB_DW'(r_cfg.screen_width);
            REG_HEIGHT:   o_prdata = APB_DW'(r_cfg.screen_height);
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/tscal_scale.sv
// ----------------------------------------------------------------------------
// tscal_scale
// One axis: window check, offset removal and Q8.16 gain with saturation.
// ----------------------------------------------------------------------------
module tscal_scale
    import tscal_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic [RAW_W-1:0]   i_raw,
    input  logic [OFF_W-1:0]   i_offset,
    input  logic [GAIN_W-1:0]  i_gain,
    output logic               o_in_win,
    output logic [COORD_W-1:0] o_coord
);

    localparam int SW = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
    localparam int DW = (SW > OFF_W) ? SW : OFF_W;
    localparam int PW = SW + GAIN_W;

    logic [SW-1:0] raw_m;
    logic [DW-1:0] raw_e;
    logic [DW-1:0] off_e;
    logic [DW-1:0] diff_e;
    logic [SW-1:0] diff;
    logic [PW-1:0] prod;

    assign o_in_win = (i_raw >= WIN_LOW) && (i_raw <= WIN_HIGH);

    assign raw_m  = i_raw[SW-1:0];
    assign raw_e  = DW'(raw_m);
    assign off_e  = DW'(i_offset);
    // offset removal floors at zero
    assign diff_e = (raw_e > off_e) ? (raw_e - off_e) : '0;
    assign diff   = diff_e[SW-1:0];
    assign prod   = PW'(diff) * PW'(i_gain);

    // drop the fraction, saturate to 16 bits
    assign o_coord = ((prod >> (FRAC_W + COORD_W)) != '0) ? '1
                   : prod[FRAC_W+COORD_W-1:FRAC_W];

endmodule

### rtl/tscal_orient.sv
// ----------------------------------------------------------------------------
// tscal_orient
// Applies the screen orientation and clamps both coordinates to the screen.
// ----------------------------------------------------------------------------
module tscal_orient
    import tscal_pkg::*;
(
    input  logic                i_level,
    input  logic [COORD_W-1:0]  i_cx,
    input  logic [COORD_W-1:0]  i_cy,
    input  logic [ORIENT_W-1:0] i_orient,
    input  logic [SIZE_W-1:0]   i_width,
    input  logic [SIZE_W-1:0]   i_height,
    output logic [POS_W-1:0]    o_pos_x,
    output logic [POS_W-1:0]    o_pos_y
);

    function automatic logic [COORD_W-1:0] mirror(
        input logic [COORD_W-1:0] a,
        input logic [SIZE_W-1:0]  b
    );
        logic [COORD_W-1:0] be;
        be = COORD_W'(b);
        return (a > be) ? '0 : (be - a);
    endfunction

    function automatic logic [POS_W-1:0] clamp_to(
        input logic [COORD_W-1:0] v,
        input logic [SIZE_W-1:0]  size
    );
        logic [SIZE_W-1:0] lim;
        lim = (size != '0) ? (size - 1'b1) : '0;
        return (v >= COORD_W'(size)) ? POS_W'(lim) : v[POS_W-1:0];
    endfunction

    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;

    always_comb begin
        case (t_orient'(i_orient))
            ORIENT_PORTRAIT: begin
                px = i_cx;
                py = i_cy;
            end
            ORIENT_LANDSCAPE: begin
                px = i_cy;
                py = mirror(i_cx, i_width);
            end
            ORIENT_PORTRAIT_180: begin
                px = mirror(i_cx, i_width);
                py = mirror(i_cy, i_height);
            end
            ORIENT_LANDSCAPE_270: begin
                px = mirror(i_cy, i_height);
                py = i_cx;
            end
            default: begin
                px = i_cx;
                py = i_cy;
            end
        endcase
    end

    // a release reports the origin
    assign o_pos_x = i_level ? clamp_to(px, i_width)  : '0;
    assign o_pos_y = i_level ? clamp_to(py, i_height) : '0;

endmodule

### rtl/tscal_chk.sv
// ----------------------------------------------------------------------------
// tscal_chk
// Port-level checks on the touch calibration core, bound to the top level.
// ----------------------------------------------------------------------------
module tscal_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [31:0]       m_axis_tdata,
    input logic              m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // release reports the origin
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)
        else $error("release with nonzero coordinates");

    // clamp keeps both coordinates inside the largest screen
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:0] <= 12'd4094)
                       && (m_axis_tdata[23:12] <= 12'd4094))
        else $error("coordinate beyond screen clamp");

    // with the result slot empty the input side takes a word
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind touch_sample_calibrate_orient_core tscal_chk u_tscal_chk (.*);
